>>> design/mbe_pkg.sv
`default_nettype none

package mbe_pkg;

  // Data bits sent per byte, most significant first
  localparam int unsigned DATA_BITS = 8;
  localparam int unsigned BIT_IDX_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;

  // Field widths fixed by the line format
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned REPS_W  = 3;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [REPS_W-1:0] MAX_WAKE_REPEATS = 3'd5;
  // Position of the closing low of a wake block (levels 0..7 alternate, 8 is low)
  localparam logic [3:0] WAKE_STEP_LAST = 4'd8;

  // Register reset values
  localparam logic [REPS_W-1:0] RST_WAKE_REPEATS  = 3'd3;
  localparam logic [TIME_W-1:0] RST_WAKE_BIT_TIME = 16'd27450;
  localparam logic [TIME_W-1:0] RST_HEADER_TIME   = 16'd24450;
  localparam logic [TIME_W-1:0] RST_HALF_BIT_TIME = 16'd21187;
  localparam logic [TIME_W-1:0] RST_TAIL_TIME     = 16'd996;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAKE_REPEATS  = 3'd0,
    CFG_WAKE_BIT_TIME = 3'd1,
    CFG_HEADER_TIME   = 3'd2,
    CFG_HALF_BIT_TIME = 3'd3,
    CFG_TAIL_TIME     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [REPS_W-1:0] wake_repeats;
    logic [TIME_W-1:0] wake_bit_time;
    logic [TIME_W-1:0] header_time;
    logic [TIME_W-1:0] half_bit_time;
    logic [TIME_W-1:0] tail_time;
  } mbe_cfg_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] data;
    logic [REPS_W-1:0]    blocks;
  } mbe_entry_t;

  typedef struct packed {
    logic       valid;
    mbe_entry_t entry;
  } mbe_head_t;

endpackage

`default_nettype wire

>>> design/manchester_byte_line_encoder_unit.sv
// Channel | Dir | Handshake            | Payload
// --------+-----+----------------------+------------------------------------------
// in      | in  | in_valid_i/in_ready_o | data_byte_i[7:0]
// out     | out | out_valid_o/out_ready_i | line_level_o, hold_time_o[15:0], last_of_run_o
// cfg     | in  | cfg_we_i (no wait)    | cfg_idx_i[2:0], cfg_wdata_i[15:0]
//
// One byte yields 9*W + 2 + 2*DATA_BITS + 1 beats, W the wake block count
// clamped to 5: 19 to 64 beats, one per cycle from the back sequencer while
// the out channel takes them. Bytes are accepted while earlier runs play out,
// until the two-entry queue is full. Reset is asynchronous, active low; it
// restores the register defaults and empties the queue and output register.
// A stalled out beat holds; the sequencer waits behind it.
`default_nettype none

module manchester_byte_line_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        line_level_o,
  output logic [15:0] hold_time_o,
  output logic        last_of_run_o
);
  import mbe_pkg::*;

  mbe_cfg_t   cfg;
  mbe_entry_t q_entry;
  mbe_head_t  q_head;
  logic       q_full, q_push, q_pop;

  // Front: register file, byte acceptance, wake count clamp
  mbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_entry),
    .cfg_o       (cfg)
  );

  // Queue: decouples byte intake from the level sequencer
  mbe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head)
  );

  // Back: walks wake, header, data and tail levels into the output register
  mbe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .head_i        (q_head),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .line_level_o  (line_level_o),
    .hold_time_o   (hold_time_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

>>> design/mbe_front.sv
`default_nettype none

module mbe_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [15:0]               cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output mbe_pkg::mbe_entry_t       q_entry_o,
  output mbe_pkg::mbe_cfg_t         cfg_o
);
  import mbe_pkg::*;

  mbe_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wake_repeats  <= RST_WAKE_REPEATS;
      cfg_q.wake_bit_time <= RST_WAKE_BIT_TIME;
      cfg_q.header_time   <= RST_HEADER_TIME;
      cfg_q.half_bit_time <= RST_HALF_BIT_TIME;
      cfg_q.tail_time     <= RST_TAIL_TIME;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WAKE_REPEATS:  cfg_q.wake_repeats  <= cfg_wdata_i[REPS_W-1:0];
        CFG_WAKE_BIT_TIME: cfg_q.wake_bit_time <= cfg_wdata_i;
        CFG_HEADER_TIME:   cfg_q.header_time   <= cfg_wdata_i;
        CFG_HALF_BIT_TIME: cfg_q.half_bit_time <= cfg_wdata_i;
        CFG_TAIL_TIME:     cfg_q.tail_time     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o      = cfg_q;
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify: clamp the wake block count, keep the data bits that go out
  assign q_entry_o.data   = data_byte_i[DATA_BITS-1:0];
  assign q_entry_o.blocks = (cfg_q.wake_repeats > MAX_WAKE_REPEATS) ? MAX_WAKE_REPEATS
                                                                    : cfg_q.wake_repeats;

endmodule

`default_nettype wire

>>> design/mbe_queue.sv
`default_nettype none

module mbe_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mbe_pkg::mbe_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output mbe_pkg::mbe_head_t  head_o
);
  import mbe_pkg::*;

  mbe_entry_t           mem_q [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]   cnt_q;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    logic [Q_PTR_W-1:0] r;
    if (p == Q_PTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + Q_PTR_W'(1);
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + Q_CNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - Q_CNT_W'(1);
    end
  end

  assign full_o       = (cnt_q == Q_CNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> design/mbe_back.sv
`default_nettype none

module mbe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mbe_pkg::mbe_cfg_t  cfg_i,
  input  mbe_pkg::mbe_head_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               line_level_o,
  output logic [15:0]        hold_time_o,
  output logic               last_of_run_o
);
  import mbe_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_WAKE, PH_HDR, PH_DATA, PH_TAIL
  } phase_e;

  phase_e                phase_q, phase_d, eff_phase;
  logic [3:0]            cnt_q, cnt_d, eff_cnt;
  logic [REPS_W-1:0]     blk_q, blk_d, eff_blk;
  logic [BIT_IDX_W-1:0]  bit_q, bit_d, eff_bit;
  logic [DATA_BITS-1:0]  byte_q, byte_d, eff_byte;
  logic                  out_valid_q, out_valid_d;
  logic                  level_q, level_d;
  logic [TIME_W-1:0]     hold_q, hold_d;
  logic                  last_q, last_d;
  logic                  adv, go;

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    blk_d       = blk_q;
    bit_d       = bit_q;
    byte_d      = byte_q;
    out_valid_d = out_valid_q;
    level_d     = level_q;
    hold_d      = hold_q;
    last_d      = last_q;

    // Position of the level to emit now; from the queue head when starting
    eff_phase = phase_q;
    eff_cnt   = cnt_q;
    eff_blk   = blk_q;
    eff_bit   = bit_q;
    eff_byte  = byte_q;
    if (phase_q == PH_IDLE) begin
      eff_phase = (head_i.entry.blocks != '0) ? PH_WAKE : PH_HDR;
      eff_cnt   = '0;
      eff_blk   = head_i.entry.blocks;
      eff_bit   = BIT_IDX_W'(DATA_BITS - 1);
      eff_byte  = head_i.entry.data;
    end

    adv   = !out_valid_q || out_ready_i;
    go    = adv && ((phase_q != PH_IDLE) || head_i.valid);
    pop_o = go && (phase_q == PH_IDLE);

    if (out_ready_i) out_valid_d = 1'b0;

    if (go) begin
      out_valid_d = 1'b1;
      byte_d      = eff_byte;
      blk_d       = eff_blk;
      bit_d       = eff_bit;
      cnt_d       = eff_cnt;
      last_d      = 1'b0;
      unique case (eff_phase)
        PH_WAKE: begin
          level_d = eff_cnt[0];
          hold_d  = cfg_i.wake_bit_time;
          if (eff_cnt == WAKE_STEP_LAST) begin
            cnt_d   = '0;
            blk_d   = eff_blk - REPS_W'(1);
            phase_d = (eff_blk == REPS_W'(1)) ? PH_HDR : PH_WAKE;
          end else begin
            cnt_d   = eff_cnt + 4'd1;
            phase_d = PH_WAKE;
          end
        end
        PH_HDR: begin
          level_d = ~eff_cnt[0];
          hold_d  = cfg_i.header_time;
          if (eff_cnt[0]) begin
            cnt_d   = '0;
            bit_d   = BIT_IDX_W'(DATA_BITS - 1);
            phase_d = PH_DATA;
          end else begin
            cnt_d   = 4'd1;
            phase_d = PH_HDR;
          end
        end
        PH_DATA: begin
          level_d = eff_byte[eff_bit] ^ eff_cnt[0];
          hold_d  = cfg_i.half_bit_time;
          if (eff_cnt[0]) begin
            cnt_d   = '0;
            bit_d   = eff_bit - BIT_IDX_W'(1);
            phase_d = (eff_bit == '0) ? PH_TAIL : PH_DATA;
          end else begin
            cnt_d   = 4'd1;
            phase_d = PH_DATA;
          end
        end
        PH_TAIL: begin
          level_d = 1'b0;
          hold_d  = cfg_i.tail_time;
          last_d  = 1'b1;
          phase_d = PH_IDLE;
        end
        default: begin
          out_valid_d = out_valid_q;
          phase_d     = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      blk_q       <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      blk_q       <= blk_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    level_q <= level_d;
    hold_q  <= hold_d;
    last_q  <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign line_level_o  = level_q;
  assign hold_time_o   = hold_q;
  assign last_of_run_o = last_q;

endmodule

`default_nettype wire

>>> design/mbe_checker.sv
`default_nettype none

module mbe_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic        line_level_o,
  input  logic [15:0] hold_time_o,
  input  logic        last_of_run_o
);
  import mbe_pkg::*;

  // Bytes accepted whose tail beat has not gone out yet
  logic [2:0] pend_q;
  logic       in_beat, last_beat;

  assign in_beat   = in_valid_i && in_ready_o;
  assign last_beat = out_valid_o && out_ready_i && last_of_run_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_beat && !last_beat) begin
      pend_q <= pend_q + 3'd1;
    end else if (last_beat && !in_beat) begin
      pend_q <= pend_q - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(line_level_o) &&
      $stable(hold_time_o) && $stable(last_of_run_o))
    else $error("stalled out beat changed");

  a_tail_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_run_o |-> !line_level_o)
    else $error("tail beat not low");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("out beat with no byte pending");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'(QUEUE_DEPTH + 1))
    else $error("more bytes pending than storage allows");

endmodule

bind manchester_byte_line_encoder_unit mbe_checker u_mbe_checker (.*);

`default_nettype wire

>>> dv/mbe_line_checker.sv
module mbe_line_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [mbe_pkg::TIME_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [mbe_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic                      line_level_i,
  input  logic [mbe_pkg::TIME_W-1:0] hold_time_i,
  input  logic                      last_of_run_i,
  output int                        fail_count_o,
  output int                        beats_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mbe_pkg::*;

  typedef struct packed {
    logic              level;
    logic [TIME_W-1:0] hold;
    logic              last;
  } line_beat_t;

  line_beat_t beats_due[$];
  mbe_cfg_t   shadow_cfg;
  int         mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic void push_beat(input logic level, input logic [TIME_W-1:0] hold,
                                    input logic last);
    line_beat_t beat;
    beat.level = level;
    beat.hold  = hold;
    beat.last  = last;
    beats_due.push_back(beat);
  endfunction

  // Expand one byte into its full run of line levels
  function automatic void queue_line_run(input logic [BYTE_W-1:0] data);
    logic [REPS_W-1:0] blocks;
    logic              bit_val;
    int unsigned       blk;
    int unsigned       step;
    blocks = (shadow_cfg.wake_repeats > MAX_WAKE_REPEATS) ? MAX_WAKE_REPEATS
                                                          : shadow_cfg.wake_repeats;
    for (blk = 0; blk < blocks; blk++) begin
      for (step = 0; step < WAKE_STEP_LAST; step++)
        push_beat(step[0], shadow_cfg.wake_bit_time, 1'b0);
      push_beat(1'b0, shadow_cfg.wake_bit_time, 1'b0);
    end
    push_beat(1'b1, shadow_cfg.header_time, 1'b0);
    push_beat(1'b0, shadow_cfg.header_time, 1'b0);
    for (step = 0; step < DATA_BITS; step++) begin
      bit_val = data[DATA_BITS-1-step];
      push_beat(bit_val, shadow_cfg.half_bit_time, 1'b0);
      push_beat(~bit_val, shadow_cfg.half_bit_time, 1'b0);
    end
    push_beat(1'b0, shadow_cfg.tail_time, 1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    line_beat_t due;
    if (!rst_ni) begin
      shadow_cfg.wake_repeats  <= RST_WAKE_REPEATS;
      shadow_cfg.wake_bit_time <= RST_WAKE_BIT_TIME;
      shadow_cfg.header_time   <= RST_HEADER_TIME;
      shadow_cfg.half_bit_time <= RST_HALF_BIT_TIME;
      shadow_cfg.tail_time     <= RST_TAIL_TIME;
      beats_due.delete();
      beats_due_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WAKE_REPEATS:  shadow_cfg.wake_repeats  <= cfg_wdata_i[REPS_W-1:0];
          CFG_WAKE_BIT_TIME: shadow_cfg.wake_bit_time <= cfg_wdata_i;
          CFG_HEADER_TIME:   shadow_cfg.header_time   <= cfg_wdata_i;
          CFG_HALF_BIT_TIME: shadow_cfg.half_bit_time <= cfg_wdata_i;
          CFG_TAIL_TIME:     shadow_cfg.tail_time     <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (beats_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual level %0b hold %0d last %0b",
                   $time, line_level_i, hold_time_i, last_of_run_i);
          mismatches++;
        end else begin
          due = beats_due.pop_front();
          if (line_level_i !== due.level) begin
            $display("%0t: line_level expected %0b actual %0b", $time, due.level, line_level_i);
            mismatches++;
          end
          if (hold_time_i !== due.hold) begin
            $display("%0t: hold_time expected %0d actual %0d", $time, due.hold, hold_time_i);
            mismatches++;
          end
          if (last_of_run_i !== due.last) begin
            $display("%0t: last_of_run expected %0b actual %0b", $time, due.last,
                     last_of_run_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) queue_line_run(data_byte_i);
      beats_due_o <= beats_due.size();
    end
  end

endmodule

>>> dv/manchester_byte_line_encoder_unit_tb.sv
module manchester_byte_line_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbe_pkg::*;

  // Registers live at indexes 0..CFG_NUM_REGS-1; the rest of the index space is unused
  localparam int unsigned CFG_NUM_REGS = 5;
  localparam int unsigned CFG_IDX_TOP  = (1 << CFG_IDX_W) - 1;
  localparam int unsigned MAX_GAP      = 16;
  localparam int unsigned HOLD_OFF_LEN = 300;
  localparam int unsigned SETTLE_LEN   = 8;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_BYTES  = 15;
  localparam int unsigned BURST_BYTES  = 6;
  localparam int          CYCLE_LIMIT  = 500000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [2:0]        cfg_idx_i;
  logic [TIME_W-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [BYTE_W-1:0] data_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              line_level_o;
  logic [TIME_W-1:0] hold_time_o;
  logic              last_of_run_o;

  int fail_count;
  int beats_due;
  int cycle_count = 0;

  // Pacing knobs shared between the stimulus and the receiver
  bit tx_steady   = 1'b0;
  bit rx_steady   = 1'b0;
  bit rx_hold_req = 1'b0;

  always #6 clk_i = ~clk_i;

  manchester_byte_line_encoder_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_level_o (line_level_o),
    .hold_time_o  (hold_time_o),
    .last_of_run_o(last_of_run_o)
  );

  mbe_line_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_level_i (line_level_o),
    .hold_time_i  (hold_time_o),
    .last_of_run_i(last_of_run_o),
    .fail_count_o (fail_count),
    .beats_due_o  (beats_due)
  );

  // Abort a hung run; the bound covers every byte at 64 beats, each stalled
  // the longest, plus every sender gap and the long hold-offs, several times over.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Receiver: before each beat, drop ready for a random stall, then hold ready
  // until a beat moves. On request, hold off for a long stretch so the input
  // queue fills up behind the stalled output.
  initial begin
    int stall;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        stall       = HOLD_OFF_LEN;
        rx_hold_req = 1'b0;
      end else if (rx_steady) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offer one byte after a random gap; return at the edge that takes the beat.
  // Valid stays high on return so a zero gap gives back-to-back beats.
  task automatic send_byte(input logic [BYTE_W-1:0] data);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // One register write per cycle; the caller drops the enable after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [TIME_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // Stop offering and wait until every predicted beat has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (beats_due != 0) @(posedge clk_i);
    repeat (SETTLE_LEN) @(posedge clk_i);
  endtask

  // Lean on the extremes: zero and full-scale hold times show up often
  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return TIME_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int unsigned phase;
    int unsigned k;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_WAKE_REPEATS;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    data_byte_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: all-zero, all-one, single-bit and alternating bytes
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'hA5);
    send_byte(8'h5A);
    drain();

    // No wake blocks and zero hold times everywhere
    write_reg(CFG_WAKE_REPEATS, '0);
    write_reg(CFG_WAKE_BIT_TIME, '0);
    write_reg(CFG_HEADER_TIME, '0);
    write_reg(CFG_HALF_BIT_TIME, '0);
    write_reg(CFG_TAIL_TIME, '0);
    cfg_we_i <= 1'b0;
    send_byte(8'h00);
    send_byte(8'hFF);
    drain();

    // Longest legal run with full-scale hold times
    write_reg(CFG_WAKE_REPEATS, TIME_W'(MAX_WAKE_REPEATS));
    write_reg(CFG_WAKE_BIT_TIME, '1);
    write_reg(CFG_HEADER_TIME, '1);
    write_reg(CFG_HALF_BIT_TIME, '1);
    write_reg(CFG_TAIL_TIME, '1);
    cfg_we_i <= 1'b0;
    send_byte(8'h3C);
    send_byte(8'hC3);
    drain();

    // Wake count above the limit, written with junk in the upper bits, and
    // writes to the unused indexes that must leave every register alone
    write_reg(CFG_WAKE_REPEATS, 16'hFFFE);
    for (k = CFG_NUM_REGS; k <= CFG_IDX_TOP; k++)
      write_reg(3'(k), TIME_W'($urandom_range(0, 65535)));
    cfg_we_i <= 1'b0;
    send_byte(8'h96);
    drain();
    write_reg(CFG_WAKE_REPEATS, 16'h0007);
    write_reg(CFG_TAIL_TIME, 16'h0001);
    cfg_we_i <= 1'b0;
    send_byte(8'h69);
    drain();

    // Random phases: fresh settings each time, mixed pacing on both sides
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      write_reg(CFG_WAKE_REPEATS, TIME_W'($urandom_range(0, 65535)));
      write_reg(CFG_WAKE_BIT_TIME, pick_time());
      write_reg(CFG_HEADER_TIME, pick_time());
      write_reg(CFG_HALF_BIT_TIME, pick_time());
      write_reg(CFG_TAIL_TIME, pick_time());
      if ($urandom_range(0, 1))
        write_reg(3'($urandom_range(CFG_NUM_REGS, CFG_IDX_TOP)),
                  TIME_W'($urandom_range(0, 65535)));
      cfg_we_i <= 1'b0;
      tx_steady = (phase % 3 == 1);
      rx_steady = (phase % 3 == 2);
      for (k = 0; k < PHASE_BYTES; k++)
        send_byte(BYTE_W'($urandom_range(0, 255)));

      // Midway, stall the output for a long stretch while bytes keep coming
      if (phase == RAND_PHASES / 2) begin
        rx_hold_req = 1'b1;
        tx_steady   = 1'b1;
        for (k = 0; k < BURST_BYTES; k++)
          send_byte(BYTE_W'($urandom_range(0, 255)));
      end
      drain();
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (SETTLE_LEN * 4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> manchester_byte_line_encoder_unit.f
design/mbe_pkg.sv
design/mbe_front.sv
design/mbe_queue.sv
design/mbe_back.sv
design/manchester_byte_line_encoder_unit.sv
design/mbe_checker.sv
dv/mbe_line_checker.sv
dv/manchester_byte_line_encoder_unit_tb.sv
